// ===== src/utf8e_pkg.sv =====
// Shared types and constants for the UTF-8 byte encoder.
`timescale 1ns / 1ps
package utf8e_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [31:0] MAX_LEN1 = 32'h0000_007F;
    localparam logic [31:0] MAX_LEN2 = 32'h0000_07FF;
    localparam logic [31:0] MAX_LEN3 = 32'h0000_FFFF;
    localparam logic [31:0] MAX_LEN4 = 32'h001F_FFFF;
    localparam logic [31:0] MAX_LEN5 = 32'h03FF_FFFF;
    localparam logic [31:0] MAX_LEN6 = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_UNICODE = 32'h0010_FFFF;
    localparam logic [31:0] NONCHAR_FFFE = 32'h0000_FFFE;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;
    localparam logic [2:0] LEN_5 = 3'd5;
    localparam logic [2:0] LEN_6 = 3'd6;

    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;

    // One classified request: bytes packed lead byte in [31:24].
    typedef struct packed {
        logic [31:0] bytes;
        logic [1:0]  last_idx;
        logic [2:0]  seq_length;
        logic        invalid;
    } utf8e_entry_t;

endpackage

// ===== src/utf8e_front.sv =====
// Front end: accepts code points, classifies length and builds the byte group.
`timescale 1ns / 1ps
module utf8e_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_code_point,
    input  logic                  q_full,
    output logic                  q_push,
    output utf8e_pkg::utf8e_entry_t q_entry
);
    import utf8e_pkg::*;

    logic [2:0] len;
    logic       rejected;
    logic [31:0] cp;

    assign cp = s_code_point;
    assign s_ready = !q_full;
    assign q_push = s_valid && !q_full;

    always_comb begin
        if (cp <= MAX_LEN1) begin
            len = LEN_1;
        end else if (cp <= MAX_LEN2) begin
            len = LEN_2;
        end else if (cp <= MAX_LEN3) begin
            len = LEN_3;
        end else if (cp <= MAX_LEN4) begin
            len = LEN_4;
        end else if (cp <= MAX_LEN5) begin
            len = LEN_5;
        end else if (cp <= MAX_LEN6) begin
            len = LEN_6;
        end else begin
            len = LEN_NONE;
        end
    end

    // 0xFFFE and 0xFFFF differ only in bit 0
    always_comb begin
        rejected = (len == LEN_NONE) || (len == LEN_5) || (len == LEN_6)
                || ((len == LEN_3) && (cp[31:1] == NONCHAR_FFFE[31:1]))
                || ((len == LEN_4) && (cp > MAX_UNICODE));
    end

    always_comb begin
        q_entry.seq_length = len;
        q_entry.invalid = rejected;
        q_entry.bytes = '0;
        q_entry.last_idx = 2'd0;
        if (!rejected) begin
            case (len)
                LEN_1: begin
                    q_entry.bytes = {1'b0, cp[6:0], 24'd0};
                    q_entry.last_idx = 2'd0;
                end
                LEN_2: begin
                    q_entry.bytes = {LEAD_2 | {3'd0, cp[10:6]},
                                     CONT_MARK | {2'd0, cp[5:0]}, 16'd0};
                    q_entry.last_idx = 2'd1;
                end
                LEN_3: begin
                    q_entry.bytes = {LEAD_3 | {4'd0, cp[15:12]},
                                     CONT_MARK | {2'd0, cp[11:6]},
                                     CONT_MARK | {2'd0, cp[5:0]}, 8'd0};
                    q_entry.last_idx = 2'd2;
                end
                default: begin
                    q_entry.bytes = {LEAD_4 | {5'd0, cp[20:18]},
                                     CONT_MARK | {2'd0, cp[17:12]},
                                     CONT_MARK | {2'd0, cp[11:6]},
                                     CONT_MARK | {2'd0, cp[5:0]}};
                    q_entry.last_idx = 2'd3;
                end
            endcase
        end
    end

endmodule

// ===== src/utf8e_queue.sv =====
// Small FIFO of classified requests between front and back end.
`timescale 1ns / 1ps
module utf8e_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  utf8e_pkg::utf8e_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output utf8e_pkg::utf8e_entry_t head_entry,
    output logic [utf8e_pkg::QCNT_W-1:0] level
);
    import utf8e_pkg::*;

    utf8e_entry_t mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign level = count_reg;
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/utf8e_back.sv =====
// Back end: walks the bytes of the head request into the output register.
`timescale 1ns / 1ps
module utf8e_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  utf8e_pkg::utf8e_entry_t head_entry,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic [2:0]              m_seq_length,
    output logic                    m_invalid,
    output logic                    m_last
);
    import utf8e_pkg::*;

    logic       m_valid_reg, m_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic [2:0] len_reg;
    logic       inv_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;
    logic [7:0] cur_byte;

    assign load = head_valid && (!m_valid_reg || m_ready);
    assign at_last = (idx_reg == head_entry.last_idx);
    assign pop = load && at_last;

    always_comb begin
        case (idx_reg)
            2'd0: cur_byte = head_entry.bytes[31:24];
            2'd1: cur_byte = head_entry.bytes[23:16];
            2'd2: cur_byte = head_entry.bytes[15:8];
            default: cur_byte = head_entry.bytes[7:0];
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        idx_next = idx_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next = at_last ? 2'd0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= cur_byte;
            len_reg <= head_entry.seq_length;
            inv_reg <= head_entry.invalid;
            last_reg <= at_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = byte_reg;
    assign m_seq_length = len_reg;
    assign m_invalid = inv_reg;
    assign m_last = last_reg;

endmodule

// ===== src/utf8_byte_encoder_unit.sv =====
// Top level of the UTF-8 byte encoder: front end, request queue, byte emitter.
//
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+-----------------------------
//  input    | s_valid s_ready s_code_point            | one code point per request
//  result   | m_valid m_ready m_out_byte m_seq_length | one byte per result, lead
//           | m_invalid m_last                        | byte first, last flagged
//
// A code point is classified in the cycle it is taken and queued (4 deep).
// The emitter sends one result per cycle while results are taken and a request
// waits: one byte for single-byte code points and rejects, two to four for
// longer ones. Requests are queued, bytes held in the output register. aresetn
// is synchronous and empties the queue and output register. Either side may stall.
`timescale 1ns / 1ps
module utf8_byte_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_code_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [2:0]  m_seq_length,
    output logic        m_invalid,
    output logic        m_last
);
    import utf8e_pkg::*;

    utf8e_entry_t push_entry;
    utf8e_entry_t head_entry;
    logic q_push, q_full, q_pop, q_head_valid;
    logic [QCNT_W-1:0] q_level;

    utf8e_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_point (s_code_point),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    utf8e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (head_entry),
        .level      (q_level)
    );

    utf8e_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_entry   (head_entry),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_seq_length (m_seq_length),
        .m_invalid    (m_invalid),
        .m_last       (m_last)
    );

    a_invalid_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_last && (m_out_byte == 8'd0)))
        else $error("rejected code point result not a lone zero byte");

    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_invalid) |-> (m_seq_length != LEN_NONE && m_seq_length <= LEN_4))
        else $error("encoded result with impossible length");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QCNT_W'(QDEPTH))
        else $error("request queue overfilled");

    a_ready_tracks_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (q_level != QCNT_W'(QDEPTH)))
        else $error("input ready disagrees with queue level");

endmodule

// ===== tb/sv/utf8_encode_checker.sv =====
// Checker for the UTF-8 byte encoder: predicts the bytes of each request and compares results.
`timescale 1ns / 1ps
module utf8_encode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_code_point,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic [2:0]  m_seq_length,
    input  logic        m_invalid,
    input  logic        m_last,
    output int          mismatch_count,
    output int          expected_left
);
    import utf8e_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] seq_length;
        logic       invalid;
        logic       last;
    } utf8_result_t;

    utf8_result_t pending_results [$];
    int fail_total = 0;

    // Queue the results one code point should produce, lead byte first.
    task automatic predict_encoding(input logic [31:0] cp);
        logic [2:0]   len;
        logic         rejected;
        logic [7:0]   enc [4];
        utf8_result_t r;
        if (cp <= MAX_LEN1) len = LEN_1;
        else if (cp <= MAX_LEN2) len = LEN_2;
        else if (cp <= MAX_LEN3) len = LEN_3;
        else if (cp <= MAX_LEN4) len = LEN_4;
        else if (cp <= MAX_LEN5) len = LEN_5;
        else if (cp <= MAX_LEN6) len = LEN_6;
        else len = LEN_NONE;
        // surrogates pass through as plain three-byte sequences
        rejected = (len == LEN_NONE) || (len >= LEN_5)
                || (len == LEN_3 && (cp == NONCHAR_FFFE || cp == MAX_LEN3))
                || (len == LEN_4 && cp > MAX_UNICODE);
        if (rejected) begin
            r.out_byte = 8'h00;
            r.seq_length = len;
            r.invalid = 1'b1;
            r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            case (len)
                LEN_1: begin
                    enc[0] = {1'b0, cp[6:0]};
                end
                LEN_2: begin
                    enc[0] = LEAD_2 | {3'b000, cp[10:6]};
                    enc[1] = CONT_MARK | {2'b00, cp[5:0]};
                end
                LEN_3: begin
                    enc[0] = LEAD_3 | {4'b0000, cp[15:12]};
                    enc[1] = CONT_MARK | {2'b00, cp[11:6]};
                    enc[2] = CONT_MARK | {2'b00, cp[5:0]};
                end
                default: begin
                    enc[0] = LEAD_4 | {5'b00000, cp[20:18]};
                    enc[1] = CONT_MARK | {2'b00, cp[17:12]};
                    enc[2] = CONT_MARK | {2'b00, cp[11:6]};
                    enc[3] = CONT_MARK | {2'b00, cp[5:0]};
                end
            endcase
            for (int k = 0; k < int'(len); k++) begin
                r.out_byte = enc[k];
                r.seq_length = len;
                r.invalid = 1'b0;
                r.last = (k == int'(len) - 1);
                pending_results.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        utf8_result_t got;
        utf8_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predict_encoding(s_code_point);
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_seq_length, m_invalid, m_last};
                if (pending_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected result: byte %02h len %0d invalid %b last %b",
                                 got.out_byte, got.seq_length, got.invalid, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display("mismatch: expected %02h/%0d/%b/%b got %02h/%0d/%b/%b",
                                     want.out_byte, want.seq_length, want.invalid, want.last,
                                     got.out_byte, got.seq_length, got.invalid, got.last);
                    end
                end
            end
        end
        mismatch_count <= fail_total;
        expected_left <= pending_results.size();
    end

endmodule

// ===== tb/sv/utf8_byte_encoder_unit_test.sv =====
// Testbench top for the UTF-8 byte encoder: stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps
module utf8_byte_encoder_unit_test;
    import utf8e_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int IDLE_PCT = 23;
    localparam int DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_code_point;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic [2:0]  m_seq_length;
    logic        m_invalid;
    logic        m_last;
    logic        calm;
    int          mismatch_count;
    int          expected_left;

    logic [31:0] corner_points [$];

    utf8_byte_encoder_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_point (s_code_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_seq_length (m_seq_length),
        .m_invalid    (m_invalid),
        .m_last       (m_last)
    );

    utf8_encode_checker enc_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_point   (s_code_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_seq_length   (m_seq_length),
        .m_invalid      (m_invalid),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_400_000;
        $display("TB_ERROR");
        $finish;
    end

    // Random backpressure on the result side, none while calm is set.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Holds the request until taken; returns on the accepting edge with valid still high.
    task automatic send_code_point(input logic [31:0] cp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_code_point <= cp;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        int unsigned pick;
        logic [31:0] cp;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_code_point <= '0;
        calm <= 1'b0;
        corner_points = '{32'h0000_0000, 32'h0000_0024, MAX_LEN1, MAX_LEN1 + 1,
                          32'h0000_20AC, MAX_LEN2, MAX_LEN2 + 1, 32'h0000_D800,
                          32'h0000_DFFF, 32'h0000_FFFD, NONCHAR_FFFE, MAX_LEN3,
                          MAX_LEN3 + 1, 32'h0001_F600, MAX_UNICODE, MAX_UNICODE + 1,
                          MAX_LEN4, MAX_LEN4 + 1, MAX_LEN5, MAX_LEN5 + 1,
                          MAX_LEN6, MAX_LEN6 + 1, 32'hFFFF_FFFF};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_points[i]) send_code_point(corner_points[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 100 && n < 180);
            pick = $urandom_range(99);
            if (pick < 25) cp = $urandom_range(MAX_LEN1, 0);
            else if (pick < 45) cp = $urandom_range(MAX_LEN2, MAX_LEN1 + 1);
            else if (pick < 63) cp = $urandom_range(MAX_LEN3, MAX_LEN2 + 1);
            else if (pick < 66) cp = $urandom_range(32'h0000_DFFF, 32'h0000_D800);
            else if (pick < 68) cp = NONCHAR_FFFE | $urandom_range(1);
            else if (pick < 83) cp = $urandom_range(MAX_UNICODE, MAX_LEN3 + 1);
            else if (pick < 88) cp = $urandom_range(MAX_LEN4, MAX_UNICODE + 1);
            else if (pick < 90) cp = $urandom_range(MAX_LEN5, MAX_LEN4 + 1);
            else if (pick < 92) cp = $urandom_range(MAX_LEN6, MAX_LEN5 + 1);
            else if (pick < 96) cp = $urandom_range(32'hFFFF_FFFF, MAX_LEN6 + 1);
            else cp = $urandom();
            send_code_point(cp);
        end

        s_valid <= 1'b0;
        calm <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_left == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
